/* hw/rtl/ilid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, request kinds, status codes and the command that steers the cells.
// ----------------------------------------------------------------------------
package ilid_pkg;

   localparam int CAPACITY    = 64;
   localparam int ELEM_WIDTH  = 8;

   // Fixed field widths of the request and response channels.
   localparam int KIND_WIDTH  = 3;
   localparam int POS_WIDTH   = 6;
   localparam int VALUE_WIDTH = 8;
   localparam int COUNT_WIDTH = 7;
   localparam int STAT_WIDTH  = 2;

   localparam int IDX_WIDTH   = $clog2(CAPACITY);
   localparam int CNT_WIDTH   = $clog2(CAPACITY + 1);
   localparam int CMP_WIDTH   = (POS_WIDTH > CNT_WIDTH) ? POS_WIDTH : CNT_WIDTH;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_READ   = 3'd3,
      KIND_DROP   = 3'd4
   } kind_type;

   typedef enum logic [STAT_WIDTH-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain in the cycle a request is taken.
   typedef struct packed {
      logic                  ins;
      logic                  del;
      logic                  rd;
      logic [IDX_WIDTH-1:0]  pos;
      logic [ELEM_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* hw/rtl/ilid_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilid_req_if;
   logic                               valid;
   logic                               ready;
   logic [ilid_pkg::KIND_WIDTH-1:0]    kind;
   logic [ilid_pkg::POS_WIDTH-1:0]     position;
   logic [ilid_pkg::VALUE_WIDTH-1:0]   item_value;

   modport source (output valid, kind, position, item_value, input ready);
   modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface ilid_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ilid_pkg::VALUE_WIDTH-1:0]   read_value;
   logic [ilid_pkg::COUNT_WIDTH-1:0]   item_count;
   logic [ilid_pkg::STAT_WIDTH-1:0]    status;

   modport source (output valid, read_value, item_count, status, input ready);
   modport sink   (input valid, read_value, item_count, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ilid_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one element; takes the new value or its left neighbor on insert, its
// right neighbor on delete, and shows its element on a read that addresses it.
// ----------------------------------------------------------------------------
module ilid_cell (
   input  wire                               clock,
   input  wire [ilid_pkg::IDX_WIDTH-1:0]     cell_index,
   input  wire ilid_pkg::cell_cmd_type       cmd,
   input  wire [ilid_pkg::ELEM_WIDTH-1:0]    left_data,
   input  wire [ilid_pkg::ELEM_WIDTH-1:0]    right_data,
   output logic [ilid_pkg::ELEM_WIDTH-1:0]   data_out,
   output logic [ilid_pkg::ELEM_WIDTH-1:0]   read_out
);
   import ilid_pkg::*;

   logic [ELEM_WIDTH-1:0] elem_ff;
   logic [ELEM_WIDTH-1:0] elem_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (cell_index == cmd.pos);
   assign above_pos = (cell_index > cmd.pos);

   always_comb begin
      elem_in = elem_ff;
      if (cmd.ins) begin
         if (at_pos) begin
            elem_in = cmd.value;
         end else if (above_pos) begin
            elem_in = left_data;
         end
      end else if (cmd.del && (at_pos || above_pos)) begin
         elem_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign data_out = elem_ff;
   assign read_out = (cmd.rd && at_pos) ? elem_ff : '0;

endmodule
`default_nettype wire

/* hw/rtl/ilid_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list control
// Checks each request against the count, steers the cells, keeps the count
// and holds the response register.
// ----------------------------------------------------------------------------
module ilid_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   ilid_req_if.sink                          req_chan,
   ilid_rsp_if.source                        rsp_chan,
   input  wire [ilid_pkg::ELEM_WIDTH-1:0]    cell_read_data,
   output ilid_pkg::cell_cmd_type            cell_cmd
);
   import ilid_pkg::*;

   logic [CNT_WIDTH-1:0]   count_ff;
   logic [CNT_WIDTH-1:0]   count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ELEM_WIDTH-1:0]  rsp_read_ff;
   logic [CNT_WIDTH-1:0]   rsp_count_ff;
   status_type             rsp_status_ff;

   logic                   accept;
   logic [CMP_WIDTH-1:0]   pos_wide;
   logic [CMP_WIDTH-1:0]   count_wide;
   logic                   is_full;
   logic                   is_empty;
   status_type             status;
   logic                   do_ins;
   logic                   do_del;
   logic                   do_rd;
   logic                   use_count_pos;

   assign accept     = req_chan.valid && req_chan.ready;
   assign pos_wide   = CMP_WIDTH'(req_chan.position);
   assign count_wide = CMP_WIDTH'(count_ff);
   assign is_full    = (count_ff >= CNT_WIDTH'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      status        = STAT_OK;
      do_ins        = 1'b0;
      do_del        = 1'b0;
      do_rd         = 1'b0;
      use_count_pos = 1'b0;
      count_in      = count_ff;
      unique case (kind_type'(req_chan.kind))
         KIND_APPEND: begin
            if (is_full) begin
               status = STAT_FULL;
            end else begin
               do_ins        = 1'b1;
               use_count_pos = 1'b1;
               count_in      = count_ff + 1'b1;
            end
         end
         KIND_INSERT: begin
            if (is_full) begin
               status = STAT_FULL;
            end else if (pos_wide > count_wide) begin
               status = STAT_BADPOS;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_DELETE: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else if (pos_wide >= count_wide) begin
               status = STAT_BADPOS;
            end else begin
               do_del   = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_READ: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else if (pos_wide >= count_wide) begin
               status = STAT_BADPOS;
            end else begin
               do_rd = 1'b1;
            end
         end
         KIND_DROP: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
   end

   // Append is an insert at the current count; both only fire below capacity.
   always_comb begin
      cell_cmd.ins   = accept && do_ins;
      cell_cmd.del   = accept && do_del;
      cell_cmd.rd    = accept && do_rd;
      cell_cmd.pos   = use_count_pos ? IDX_WIDTH'(count_ff) : IDX_WIDTH'(req_chan.position);
      cell_cmd.value = ELEM_WIDTH'(req_chan.item_value);
   end

   // A new request is taken whenever the response register is free or drains now.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_ff   <= do_rd ? cell_read_data : '0;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = VALUE_WIDTH'(rsp_read_ff);
   assign rsp_chan.item_count = COUNT_WIDTH'(rsp_count_ff);
   assign rsp_chan.status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(CAPACITY))
      else $error("element count above capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_rsp_count_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == count_ff))
      else $error("response count differs from stored count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_FULL))
         |-> (count_ff == CNT_WIDTH'(CAPACITY)))
      else $error("full status while list not full");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_read_ff == '0))
      else $error("nonzero read value on failed request");
`endif

endmodule
`default_nettype wire

/* hw/rtl/indexed_list_insert_delete_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list with insert and delete at a position
// A chain of element cells that shift up on insert and down on delete,
// with a control block that keeps the count and answers each request.
//
//   Channel   Direction  Payload
//   req_chan  in         kind, position, item_value
//   rsp_chan  out        read_value, item_count, status
//
// Every request is decided and applied to the cell chain in the cycle it is
// taken; its response sits in the output register from the next cycle.
// One request per cycle while the response side keeps up; the single
// response register sets that limit.
// A stalled response holds the request side only when it is not taken that cycle.
// Reset clears the count and the response valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core (
   input  wire            clock,
   input  wire            reset,
   ilid_req_if.sink       req_chan,
   ilid_rsp_if.source     rsp_chan
);
   import ilid_pkg::*;

   cell_cmd_type          cell_cmd;
   logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
   logic [ELEM_WIDTH-1:0] cell_read [CAPACITY];
   logic [ELEM_WIDTH-1:0] read_merged;

   ilid_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .cell_read_data (read_merged),
      .cell_cmd       (cell_cmd)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_data;
      logic [ELEM_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ilid_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_WIDTH'(i)),
         .cmd        (cell_cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .read_out   (cell_read[i])
      );
   end

   // Only the addressed cell drives a nonzero value, so an OR merges them.
   always_comb begin
      read_merged = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         read_merged = read_merged | cell_read[j];
      end
   end

endmodule
`default_nettype wire
